// ----- hw/rtl/ssr_pkg.sv -----
// Shared types and constants for the resampling sample store.
`timescale 1ns / 1ps
package ssr_pkg;

  localparam int FRAME_W  = 32;
  localparam int OFFSET_W = 20;
  localparam int CNT_W    = 7;
  localparam int RATE_W   = 19;
  localparam int IDX_W    = 17;
  localparam int KIND_W   = 2;

  // Q19.16 ratio of two 19-bit rates, and the widths that follow from it
  localparam int FRAC_W    = 16;
  localparam int RATIO_W   = RATE_W + FRAC_W;
  localparam int PROD_W    = RATIO_W + OFFSET_W;
  localparam int BASE_W    = PROD_W - FRAC_W;
  localparam int SRC_W     = BASE_W + 1;
  localparam int ACC_W     = RATIO_W + CNT_W;
  localparam int MUL_SPLIT = 18;
  localparam int PP_W      = MUL_SPLIT + OFFSET_W;
  localparam int DIV_CNT_W = 6;

  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 3;

  localparam logic [RATE_W-1:0]  RATE_RESET  = 19'd44100;
  localparam logic [RATIO_W-1:0] UNITY_RATIO = RATIO_W'(1) << FRAC_W;

  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FRAME  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef struct packed {
    logic                is_read;
    logic [FRAME_W-1:0]  frame;
    logic [RATIO_W-1:0]  ratio;
    logic [BASE_W-1:0]   base;
    logic [CNT_W-1:0]    count;
  } job_t;

endpackage

// ----- hw/rtl/sample_store_resampled_read.sv -----
// Top level of the sample store with nearest-neighbor resampled reads.
// Append: the front takes a new word only after pushing the last one; the memory side then loads the acknowledge.
// Unity-rate read skips the divide; a resampled read adds a restoring divide, then multiply low, high and sum.
// Back end sets up each read (SETUP1, SETUP2), then per frame does a memory read and an output load.
// A read gives up to MAX_READ frames; a stalled output holds the memory side, the queue keeps the front moving.
// Reset (rst, synchronous) empties the store, sets source_rate to 44100; frame memory is not cleared.
`timescale 1ns / 1ps
module sample_store_resampled_read #(
  parameter int DEPTH    = 65536,
  parameter int MAX_READ = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ssr_pkg::RATE_W-1:0]       cfg_data,      // source_rate
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // frame_value, read_offset, read_count, target_rate, zero pad
  input  logic [ssr_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  logic [ssr_pkg::IN_TUSER_W-1:0]   s_tuser,       // cmd
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ssr_pkg::OUT_TDATA_W-1:0]  m_tdata,       // out_frame, total_or_index, zero pad
  output logic [ssr_pkg::OUT_TUSER_W-1:0]  m_tuser,       // kind, overflow
  output logic                             m_tlast
);
  import ssr_pkg::*;

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  ssr_front #(
    .MAX_READ(MAX_READ)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  ssr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  ssr_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ----- hw/rtl/ssr_front.sv -----
// Front end: accepts words, forms the Q19.16 ratio and scaled offset, queues jobs.
`timescale 1ns / 1ps
module ssr_front #(
  parameter int MAX_READ = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ssr_pkg::RATE_W-1:0]          cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ssr_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic [ssr_pkg::IN_TUSER_W-1:0]      s_tuser,
  output logic                                push_valid,
  input  logic                                push_ready,
  output ssr_pkg::job_t                       push_job
);
  import ssr_pkg::*;

  localparam logic [2:0] F_IDLE   = 3'd0;
  localparam logic [2:0] F_DIV    = 3'd1;
  localparam logic [2:0] F_MUL_LO = 3'd2;
  localparam logic [2:0] F_MUL_HI = 3'd3;
  localparam logic [2:0] F_SUM    = 3'd4;
  localparam logic [2:0] F_PUSH   = 3'd5;

  logic [2:0]           state;
  logic [RATE_W-1:0]    source_rate;
  job_t                 job;
  logic [OFFSET_W-1:0]  offset;
  logic [RATE_W-1:0]    divisor;
  logic [RATE_W-1:0]    rem;
  logic [RATIO_W-1:0]   quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [PP_W-1:0]      pp;
  logic [PP_W-1:0]      plo;
  logic [PROD_W-1:0]    prod;

  logic                 accept;
  logic [FRAME_W-1:0]   in_frame;
  logic [OFFSET_W-1:0]  in_offset;
  logic [CNT_W-1:0]     in_count;
  logic [CNT_W-1:0]     sat_count;
  logic [RATE_W-1:0]    in_target;
  logic                 unity;
  logic [RATE_W:0]      rem_sh;
  logic                 ge;

  assign in_frame  = s_tdata[FRAME_W-1:0];
  assign in_offset = s_tdata[FRAME_W +: OFFSET_W];
  assign in_count  = s_tdata[FRAME_W+OFFSET_W +: CNT_W];
  assign in_target = s_tdata[FRAME_W+OFFSET_W+CNT_W +: RATE_W];
  assign sat_count = (in_count > CNT_W'(MAX_READ)) ? CNT_W'(MAX_READ) : in_count;
  assign unity     = (in_target == '0) || (in_target == source_rate);

  assign s_tready   = (state == F_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign push_valid = (state == F_PUSH);
  assign push_job   = job;

  // restoring divide, one quotient bit a cycle
  assign rem_sh = {rem, quo[RATIO_W-1]};
  assign ge     = (rem_sh >= {1'b0, divisor});
  assign prod   = PROD_W'(plo) + (PROD_W'(pp) << MUL_SPLIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      source_rate <= RATE_RESET;
    end else begin
      if (cfg_we && (cfg_data != '0)) begin
        source_rate <= cfg_data;
      end
      case (state)
        F_IDLE: begin
          if (accept) begin
            if (s_tuser[0] == CMD_APPEND || unity) begin
              state <= F_PUSH;
            end else begin
              state <= F_DIV;
            end
          end
        end
        F_DIV: begin
          if (div_cnt == '0) begin
            state <= F_MUL_LO;
          end
        end
        F_MUL_LO: state <= F_MUL_HI;
        F_MUL_HI: state <= F_SUM;
        F_SUM:    state <= F_PUSH;
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (accept) begin
          job.is_read <= (s_tuser[0] == CMD_READ);
          job.frame   <= in_frame;
          job.ratio   <= UNITY_RATIO;
          job.base    <= BASE_W'(in_offset);
          job.count   <= sat_count;
          offset      <= in_offset;
          divisor     <= in_target;
          rem         <= '0;
          quo         <= {source_rate, FRAC_W'(0)};
          div_cnt     <= DIV_CNT_W'(RATIO_W - 1);
        end
      end
      F_DIV: begin
        rem     <= ge ? RATE_W'(rem_sh - {1'b0, divisor}) : rem_sh[RATE_W-1:0];
        quo     <= {quo[RATIO_W-2:0], ge};
        div_cnt <= div_cnt - DIV_CNT_W'(1);
      end
      F_MUL_LO: begin
        job.ratio <= quo;
        pp        <= PP_W'(quo[MUL_SPLIT-1:0] * offset);
      end
      F_MUL_HI: begin
        plo <= pp;
        pp  <= PP_W'(job.ratio[RATIO_W-1:MUL_SPLIT] * offset);
      end
      F_SUM: begin
        job.base <= prod[PROD_W-1:FRAC_W];
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/ssr_queue.sv -----
// Short job queue between the front end and the memory side.
`timescale 1ns / 1ps
module ssr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  ssr_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output ssr_pkg::job_t pop_job
);
  import ssr_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   used;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (used != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (used != '0);
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        used <= used + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        used <= used - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ----- hw/rtl/ssr_back.sv -----
// Memory side: stores appended frames and walks resampled reads into the output register.
`timescale 1ns / 1ps
module ssr_back #(
  parameter int DEPTH = 65536
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pop_valid,
  output logic                             pop_ready,
  input  ssr_pkg::job_t                    pop_job,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ssr_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic [ssr_pkg::OUT_TUSER_W-1:0]  m_tuser,
  output logic                             m_tlast
);
  import ssr_pkg::*;

  localparam int FC_W   = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_APPEND = 3'd1;
  localparam logic [2:0] B_SETUP1 = 3'd2;
  localparam logic [2:0] B_SETUP2 = 3'd3;
  localparam logic [2:0] B_CHECK  = 3'd4;
  localparam logic [2:0] B_DATA   = 3'd5;
  localparam logic [2:0] B_EMPTY  = 3'd6;

  logic [FRAME_W-1:0] mem [DEPTH];
  logic [FRAME_W-1:0] rdata;

  logic [2:0]         state;
  logic [FC_W-1:0]    fc;
  job_t               job;
  logic [ACC_W-1:0]   acc;
  logic [SRC_W-1:0]   src;
  logic [SRC_W-1:0]   src_n;
  logic [CNT_W-1:0]   idx;
  logic               last_flag;

  logic               out_free;
  logic               full;
  logic [SRC_W-1:0]   fc_ext;
  logic [SRC_W-1:0]   src_step;
  logic               wr_en;
  logic               rd_en;
  logic               load;
  logic [KIND_W-1:0]  ld_kind;
  logic [FRAME_W-1:0] ld_frame;
  logic [IDX_W-1:0]   ld_idx;
  logic               ld_last;
  logic               ld_ovf;

  assign out_free  = !m_tvalid || m_tready;
  assign full      = (fc >= FC_W'(DEPTH));
  assign fc_ext    = SRC_W'(fc);
  assign src_step  = SRC_W'(job.base) + SRC_W'(acc[ACC_W-1:FRAC_W]);
  assign pop_ready = (state == B_IDLE);
  assign wr_en     = (state == B_APPEND) && out_free && !full;
  assign rd_en     = (state == B_CHECK);

  always_comb begin
    load     = 1'b0;
    ld_kind  = KIND_APPEND;
    ld_frame = '0;
    ld_idx   = '0;
    ld_last  = 1'b1;
    ld_ovf   = 1'b0;
    case (state)
      B_APPEND: begin
        load   = out_free;
        ld_idx = full ? IDX_W'(fc) : IDX_W'(fc + FC_W'(1));
        ld_ovf = full;
      end
      B_DATA: begin
        load     = out_free;
        ld_kind  = KIND_FRAME;
        ld_frame = rdata;
        ld_idx   = IDX_W'(idx);
        ld_last  = last_flag;
      end
      B_EMPTY: begin
        load    = out_free;
        ld_kind = KIND_EMPTY;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      fc       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (wr_en) begin
        fc <= fc + FC_W'(1);
      end
      case (state)
        B_IDLE: begin
          if (pop_valid) begin
            state <= pop_job.is_read ? B_SETUP1 : B_APPEND;
          end
        end
        B_APPEND: begin
          if (out_free) begin
            state <= B_IDLE;
          end
        end
        B_SETUP1: state <= B_SETUP2;
        B_SETUP2: state <= B_CHECK;
        B_CHECK: begin
          // only the first index can fail here; later ones were checked ahead
          if (job.count == '0 || src >= fc_ext) begin
            state <= B_EMPTY;
          end else begin
            state <= B_DATA;
          end
        end
        B_DATA: begin
          if (out_free) begin
            state <= last_flag ? B_IDLE : B_CHECK;
          end
        end
        B_EMPTY: begin
          if (out_free) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {(OUT_TDATA_W - FRAME_W - IDX_W)'(0), ld_idx, ld_frame};
      m_tuser <= {ld_ovf, ld_kind};
      m_tlast <= ld_last;
    end
    case (state)
      B_IDLE: begin
        if (pop_valid) begin
          job <= pop_job;
        end
      end
      B_SETUP1: begin
        acc <= ACC_W'(job.ratio);
        src <= SRC_W'(job.base);
        idx <= '0;
      end
      B_SETUP2: begin
        src_n <= src_step;
        acc   <= acc + ACC_W'(job.ratio);
      end
      B_CHECK: begin
        // look one index ahead so the final frame carries last
        last_flag <= (CNT_W'(idx + CNT_W'(1)) == job.count) || (src_n >= fc_ext);
      end
      B_DATA: begin
        if (out_free && !last_flag) begin
          src   <= src_n;
          src_n <= src_step;
          acc   <= acc + ACC_W'(job.ratio);
          idx   <= idx + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fc[ADDR_W-1:0]] <= job.frame;
    end
    if (rd_en) begin
      rdata <= mem[src[ADDR_W-1:0]];
    end
  end

endmodule

// ----- hw/rtl/ssr_checker.sv -----
// Port-level checks on the output stream of the sample store, bound to the top level.
`timescale 1ns / 1ps
module ssr_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [ssr_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input logic [ssr_pkg::OUT_TUSER_W-1:0]  m_tuser,
  input logic                             m_tlast
);
  import ssr_pkg::*;

  logic [KIND_W-1:0] kind;
  assign kind = m_tuser[KIND_W-1:0];

  // hold a stalled word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (kind == KIND_APPEND || kind == KIND_EMPTY) |-> m_tlast)
    else $error("single-word result without last");

  a_ovf_append: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[KIND_W] |-> kind == KIND_APPEND && m_tdata[FRAME_W-1:0] == '0)
    else $error("overflow flag on a read result");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && kind == KIND_EMPTY |-> m_tdata == '0)
    else $error("empty read result carries data");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind sample_store_resampled_read ssr_checker u_ssr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
